@@ hw/rtl/tpt_pkg.sv @@
package tpt_pkg;

  // table geometry; the home slot is taken from the low id bits, so the slot count is a power of two
  localparam int TABLE_SLOTS = 64;
  localparam int SLOT_W      = $clog2(TABLE_SLOTS);
  localparam int CNT_W       = SLOT_W + 1;

  // stream widths
  localparam int IN_DATA_W    = 256;
  localparam int IN_USER_W    = 1;
  localparam int OUT_DATA_W   = 136;
  localparam int OUT_USER_W   = 3;
  localparam int SLOT_FIELD_W = 6;

  // operation codes
  localparam logic OP_START = 1'b0;
  localparam logic OP_CHUNK = 1'b1;

  // result status codes
  typedef enum logic [2:0] {
    STS_STARTED  = 3'd0,
    STS_FULL     = 3'd1,
    STS_STORED   = 3'd2,
    STS_COMPLETE = 3'd3,
    STS_UNKNOWN  = 3'd4,
    STS_INVALID  = 3'd5
  } status_t;

  // controller states
  typedef enum logic [1:0] {
    S_IDLE,
    S_PROBE,
    S_CALC,
    S_COMMIT
  } state_t;

  // one table slot as stored in the ram
  typedef struct packed {
    logic [63:0] key;
    logic [63:0] exp_bytes;
    logic [31:0] bpc;
    logic [31:0] exp_chunks;
    logic [31:0] chunks;
    logic [63:0] bytes;
  } entry_t;

  // controller to datapath
  typedef struct packed {
    logic accept;
    logic probe;
    logic calc;
    logic commit;
  } tpt_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic probe_done;
    logic need_calc;
    logic out_free;
  } tpt_sts_t;

  // low six bits of a slot number, zero extended for small tables
  function automatic logic [SLOT_FIELD_W-1:0] slot_field(input logic [SLOT_W-1:0] s);
    logic [SLOT_W+SLOT_FIELD_W-1:0] w;
    w = {{SLOT_FIELD_W{1'b0}}, s};
    return w[SLOT_FIELD_W-1:0];
  endfunction

endpackage

@@ hw/rtl/tpt_ram.sv @@
module tpt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  // single write port, registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

@@ hw/rtl/tpt_ctrl.sv @@
module tpt_ctrl
  import tpt_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_tvalid,
  output logic     in_tready,
  input  tpt_sts_t sts,
  output tpt_cmd_t cmd
);

  state_t state_r, state_nxt;

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_tready = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.accept = 1'b1;
          state_nxt  = S_PROBE;
        end
      end
      S_PROBE: begin
        cmd.probe = 1'b1;
        if (sts.probe_done) begin
          state_nxt = sts.need_calc ? S_CALC : S_COMMIT;
        end
      end
      S_CALC: begin
        cmd.calc  = 1'b1;
        state_nxt = S_COMMIT;
      end
      S_COMMIT: begin
        if (sts.out_free) begin
          cmd.commit = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
    endcase
  end

endmodule

@@ hw/rtl/tpt_dp.sv @@
module tpt_dp
  import tpt_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic [IN_DATA_W-1:0]  in_tdata,
  input  logic [IN_USER_W-1:0]  in_tuser,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,
  output logic [OUT_USER_W-1:0] out_tuser,
  input  tpt_cmd_t              cmd,
  output tpt_sts_t              sts
);

  // latched input beat
  logic        op_r;
  logic [63:0] id_r;
  logic [63:0] fsize_r;
  logic [31:0] csize_r;
  logic [31:0] total_r;
  logic [31:0] idx_r;
  logic [31:0] len_r;

  // probe pipeline
  logic [SLOT_W-1:0] rd_addr_r, rd_addr_nxt;
  logic [SLOT_W-1:0] cmp_addr_r, cmp_addr_nxt;
  logic [CNT_W-1:0]  issued_r, issued_nxt;
  logic              cmp_valid_r, cmp_valid_nxt;
  logic              rd_en;

  // slot occupancy, cleared by reset
  logic [TABLE_SLOTS-1:0] valid_r;

  // resolved probe and arithmetic results
  status_t           code_r;
  logic [SLOT_W-1:0] slot_r;
  entry_t            entry_r;
  logic [63:0]       offset_r;
  logic [31:0]       chunks_r;
  logic [63:0]       sum_r;

  // output register
  logic                  out_valid_r;
  status_t               out_status_r;
  logic [SLOT_W-1:0]     out_slot_r;
  logic [63:0]           out_offset_r;
  logic [63:0]           out_recv_r;

  entry_t      ram_rdata;
  entry_t      wr_entry;
  logic        wr_en;
  logic        id_zero, hit_match, hit_free, found, exhausted;
  logic        complete;
  logic [64:0] sum_wide;

  tpt_ram #(
    .WIDTH ($bits(entry_t)),
    .DEPTH (TABLE_SLOTS)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (slot_r),
    .wr_data (wr_entry),
    .rd_en   (rd_en),
    .rd_addr (rd_addr_r),
    .rd_data (ram_rdata)
  );

  // input capture
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      op_r    <= in_tuser[0];
      id_r    <= in_tdata[63:0];
      fsize_r <= in_tdata[127:64];
      csize_r <= in_tdata[159:128];
      total_r <= in_tdata[191:160];
      idx_r   <= in_tdata[223:192];
      len_r   <= in_tdata[255:224];
    end
  end

  // probe issue: one slot read per cycle, compared in the next cycle
  always_comb begin
    rd_addr_nxt   = rd_addr_r;
    cmp_addr_nxt  = cmp_addr_r;
    issued_nxt    = issued_r;
    cmp_valid_nxt = 1'b0;
    rd_en         = 1'b0;
    if (cmd.accept) begin
      rd_addr_nxt = in_tdata[SLOT_W-1:0];
      issued_nxt  = '0;
    end else if (cmd.probe && issued_r < CNT_W'(TABLE_SLOTS)) begin
      rd_en         = 1'b1;
      rd_addr_nxt   = rd_addr_r + SLOT_W'(1);
      cmp_addr_nxt  = rd_addr_r;
      issued_nxt    = issued_r + CNT_W'(1);
      cmp_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      issued_r    <= '0;
      cmp_valid_r <= 1'b0;
    end else begin
      issued_r    <= issued_nxt;
      cmp_valid_r <= cmp_valid_nxt;
    end
    rd_addr_r  <= rd_addr_nxt;
    cmp_addr_r <= cmp_addr_nxt;
  end

  // slot test: a slot hits on a key match, or for start beats when it is free
  always_comb begin
    id_zero   = (id_r == 64'd0);
    hit_match = valid_r[cmp_addr_r] && (ram_rdata.key == id_r);
    hit_free  = (op_r == OP_START) && !valid_r[cmp_addr_r];
    found     = cmp_valid_r && (hit_match || hit_free);
    exhausted = cmp_valid_r && !found && (issued_r == CNT_W'(TABLE_SLOTS));
  end

  assign sts.probe_done = id_zero || found || exhausted;
  assign sts.need_calc  = !id_zero && found && (op_r == OP_CHUNK);
  assign sts.out_free   = !out_valid_r || out_tready;

  // probe resolution
  always_ff @(posedge clk) begin
    if (cmd.probe && sts.probe_done) begin
      slot_r  <= cmp_addr_r;
      entry_r <= ram_rdata;
      if (id_zero) begin
        code_r <= STS_INVALID;
      end else if (found) begin
        code_r <= (op_r == OP_START) ? STS_STARTED : STS_STORED;
      end else begin
        code_r <= (op_r == OP_START) ? STS_FULL : STS_UNKNOWN;
      end
    end
  end

  // chunk arithmetic: offset product and saturating counters
  assign sum_wide = {1'b0, entry_r.bytes} + {33'd0, len_r};

  always_ff @(posedge clk) begin
    if (cmd.calc) begin
      offset_r <= 64'(idx_r) * 64'(entry_r.bpc);
      chunks_r <= (entry_r.chunks == 32'hFFFF_FFFF) ? entry_r.chunks
                                                      : entry_r.chunks + 32'd1;
      sum_r    <= sum_wide[64] ? 64'hFFFF_FFFF_FFFF_FFFF : sum_wide[63:0];
    end
  end

  // write back and completion check
  always_comb begin
    complete = (chunks_r >= entry_r.exp_chunks) || (sum_r >= entry_r.exp_bytes);
    wr_en    = 1'b0;
    wr_entry = entry_r;
    if (code_r == STS_STARTED) begin
      wr_entry.key        = id_r;
      wr_entry.exp_bytes  = fsize_r;
      wr_entry.bpc        = csize_r;
      wr_entry.exp_chunks = total_r;
      wr_entry.chunks     = '0;
      wr_entry.bytes      = '0;
      wr_en               = cmd.commit;
    end else begin
      wr_entry.chunks = chunks_r;
      wr_entry.bytes  = sum_r;
      wr_en           = cmd.commit && (code_r == STS_STORED) && !complete;
    end
  end

  // occupancy bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (cmd.commit) begin
      if (code_r == STS_STARTED) begin
        valid_r[slot_r] <= 1'b1;
      end else if (code_r == STS_STORED && complete) begin
        valid_r[slot_r] <= 1'b0;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.commit) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
    if (cmd.commit) begin
      unique case (code_r)
        STS_STARTED: begin
          out_status_r <= STS_STARTED;
          out_slot_r   <= slot_r;
          out_offset_r <= '0;
          out_recv_r   <= '0;
        end
        STS_STORED: begin
          out_status_r <= complete ? STS_COMPLETE : STS_STORED;
          out_slot_r   <= slot_r;
          out_offset_r <= offset_r;
          out_recv_r   <= sum_r;
        end
        default: begin
          out_status_r <= code_r;
          out_slot_r   <= '0;
          out_offset_r <= '0;
          out_recv_r   <= '0;
        end
      endcase
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_status_r;
  assign out_tdata  = {2'b00, out_recv_r, out_offset_r, slot_field(out_slot_r)};

endmodule

@@ hw/rtl/transfer_progress_tracker.sv @@
// transfer progress tracker
// in channel: one beat per request; in_tuser is the operation (0 start, 1 chunk),
// in_tdata carries the id, the start metadata and the chunk header.
// out channel: one beat per request; out_tuser is the status code, out_tdata holds
// the slot, the write offset and the running byte count.
// requests are handled one at a time. the slot probe reads one table entry per
// cycle from the slot ram and compares it in the next cycle; a chunk that finds
// its slot then passes through the calc state before commit, and a zero id
// resolves at once in the probe state. a new request is taken the cycle after
// the result is loaded.
// the result sits in an output register: a stalled receiver does not stop the
// next request from being accepted and probed; it only holds the following
// write-back until the pending beat is taken.
// reset empties every slot at once through per-slot occupancy bits and drops
// any pending result beat; no clearing pass is needed.
module transfer_progress_tracker
  import tpt_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // transfer_id, file_size, chunk_size, total_chunks, chunk_index, chunk_length
  input  logic [IN_DATA_W-1:0]  in_tdata,
  // operation
  input  logic [IN_USER_W-1:0]  in_tuser,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // slot_index, write_offset, bytes_received, zero pad
  output logic [OUT_DATA_W-1:0] out_tdata,
  // status
  output logic [OUT_USER_W-1:0] out_tuser
);

  tpt_cmd_t cmd;
  tpt_sts_t sts;

  tpt_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  tpt_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cmd        (cmd),
    .sts        (sts)
  );

  // busy after a beat is accepted
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.accept |=> !in_tready)
    else $error("in_tready high right after an accepted beat");

  // a write-back never overwrites a pending result
  a_commit_room: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |-> (!out_tvalid || out_tready))
    else $error("result committed over a pending beat");

  // every write-back produces a result beat
  a_commit_valid: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |=> out_tvalid)
    else $error("commit without result beat");

  // failed requests carry no slot, offset or count
  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && (out_tuser == STS_FULL || out_tuser == STS_UNKNOWN ||
                    out_tuser == STS_INVALID)) |-> (out_tdata == '0))
    else $error("failed request with nonzero payload");

endmodule
